>>> rtl/core/ffc_pkg.sv
// Package: mode codes and shared types for the fixed/float converter.
package ffc_pkg;

  typedef enum logic [1:0] {
    MODE_INT2FIX = 2'd0,
    MODE_FLT2FIX = 2'd1,
    MODE_FIX2INT = 2'd2,
    MODE_FIX2FLT = 2'd3
  } mode_t;

  typedef struct packed {
    logic [31:0] bits;
    logic        ovf;
  } result_t;

endpackage

>>> rtl/core/fixed_float_converter.sv
// Top level: fixed/float converter with input and result registers.
// One request per cycle with no bubbles unless out_ready is low. A request goes through
// the input register, conversion logic and result register. The result register holds
// while out_ready is low and accepts a new request in the same cycle it is drained.
module fixed_float_converter #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_operand_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_bits,
  output logic        out_overflow
);

  logic        s1_vld_r;
  logic [1:0]  s1_mode_r;
  logic [31:0] s1_op_r;
  logic        s2_vld_r;
  ffc_pkg::result_t s2_res_r;
  ffc_pkg::result_t to_res, from_res, res_nxt;
  logic        s2_en, s1_en;

  assign s2_en    = !s2_vld_r || out_ready;
  assign s1_en    = !s1_vld_r || s2_en;
  assign in_ready = s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_en) begin
      s1_vld_r <= in_valid;
    end
    if (s1_en && in_valid) begin
      s1_mode_r <= in_mode;
      s1_op_r   <= in_operand_bits;
    end
  end

  ffc_to_fixed #(.FRAC_BITS(FRAC_BITS)) u_to (
    .is_float (s1_mode_r == ffc_pkg::MODE_FLT2FIX),
    .operand  (s1_op_r),
    .res      (to_res)
  );

  ffc_from_fixed #(.FRAC_BITS(FRAC_BITS)) u_from (
    .to_float (s1_mode_r == ffc_pkg::MODE_FIX2FLT),
    .operand  (s1_op_r),
    .res      (from_res)
  );

  always_comb begin
    unique case (ffc_pkg::mode_t'(s1_mode_r))
      ffc_pkg::MODE_INT2FIX, ffc_pkg::MODE_FLT2FIX: res_nxt = to_res;
      default:                                      res_nxt = from_res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_en) begin
      s2_vld_r <= s1_vld_r;
    end
    if (s2_en && s1_vld_r) begin
      s2_res_r <= res_nxt;
    end
  end

  assign out_valid       = s2_vld_r;
  assign out_result_bits = s2_res_r.bits;
  assign out_overflow    = s2_res_r.ovf;

endmodule

>>> rtl/core/ffc_to_fixed.sv
// Conversions into fixed point: int32 and float32 operands.
module ffc_to_fixed #(
  parameter int FRAC_BITS = 8
) (
  input  logic               is_float,
  input  logic [31:0]        operand,
  output ffc_pkg::result_t   res
);

  localparam int SHL_MAX = 39;

  logic        sgn;
  logic [7:0]  ex;
  logic [23:0] man;
  logic signed [10:0] sh;
  logic [5:0]  rs;
  logic [63:0] mag;
  logic [63:0] up;
  logic        f_ovf;
  logic [31:0] f_val;
  logic signed [63:0] ip;
  logic        i_ovf;

  always_comb begin
    sgn = operand[31];
    ex  = (operand[30:23] == 8'd0) ? 8'd1 : operand[30:23];
    man = {(operand[30:23] != 8'd0), operand[22:0]};
    sh  = $signed({3'd0, ex}) - 11'sd150 + 11'(FRAC_BITS);
    rs  = 6'((-sh) & 11'h3F);
    up  = 64'd0;
    mag = 64'd0;
    f_ovf = 1'b0;
    if (operand[30:23] == 8'hFF) begin
      f_ovf = 1'b1;
    end else if (man == 24'd0) begin
      mag = 64'd0;
    end else if (sh >= 0) begin
      if (sh > 11'(SHL_MAX)) f_ovf = 1'b1;
      else mag = {40'd0, man} << sh[5:0];
    end else if (-sh > 11'sd25) begin
      mag = 64'd0;
    end else begin
      up  = {40'd0, man} + (64'd1 << (rs - 6'd1));
      mag = up >> rs;
    end
    if ((!sgn && mag > 64'h7FFF_FFFF) || (sgn && mag > 64'h8000_0000)) f_ovf = 1'b1;
    f_val = f_ovf ? 32'd0 : (sgn ? 32'(-mag[31:0]) : mag[31:0]);

    ip    = 64'($signed(operand)) <<< FRAC_BITS;
    i_ovf = (ip > 64'sh7FFF_FFFF) || (ip < -64'sh8000_0000);

    if (is_float) begin
      res.bits = f_val;
      res.ovf  = f_ovf;
    end else begin
      res.bits = i_ovf ? 32'd0 : ip[31:0];
      res.ovf  = i_ovf;
    end
  end

endmodule

>>> rtl/core/ffc_from_fixed.sv
// Conversions out of fixed point: to int32 (truncating) and float32 (nearest even).
module ffc_from_fixed #(
  parameter int FRAC_BITS = 8
) (
  input  logic               to_float,
  input  logic [31:0]        operand,
  output ffc_pkg::result_t   res
);

  logic        sgn;
  logic [31:0] mag;
  logic [4:0]  p;
  logic [24:0] mant;
  logic [31:0] rem;
  logic [31:0] half;
  logic [4:0]  s;
  logic [8:0]  pe;
  logic [31:0] flt;
  logic [31:0] q;

  always_comb begin
    sgn = operand[31];
    mag = sgn ? 32'(-operand) : operand;
    p   = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) p = 5'(i);
    end
    s    = 5'd0;
    rem  = 32'd0;
    half = 32'd0;
    pe   = {4'd0, p};
    if (p <= 5'd23) begin
      mant = 25'(mag << (5'd23 - p));
    end else begin
      s    = p - 5'd23;
      rem  = mag & ((32'd1 << s) - 32'd1);
      half = 32'd1 << (s - 5'd1);
      mant = 25'(mag >> s);
      if (rem > half || (rem == half && mant[0])) mant = mant + 25'd1;
      if (mant[24]) begin
        mant = mant >> 1;
        pe   = pe + 9'd1;
      end
    end
    pe  = pe + 9'd127 - 9'(FRAC_BITS);
    flt = (mag == 32'd0) ? 32'd0 : {sgn, pe[7:0], mant[22:0]};

    // truncate toward zero: bias negatives before the arithmetic shift
    q = 32'(($signed(operand) + (sgn ? $signed(32'((1 << FRAC_BITS) - 1)) : 32'sd0))
            >>> FRAC_BITS);

    res.bits = to_float ? flt : q;
    res.ovf  = 1'b0;
  end

endmodule

>>> rtl/core/ffc_checker.sv
// Port checker for the fixed/float converter, bound to the top level.
module ffc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result_bits,
  input logic        out_overflow
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_bits))
    else $error("result changed while stalled");

  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_result_bits == 32'd0)
    else $error("overflow with nonzero result");

  a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("not ready while output drains");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind fixed_float_converter ffc_checker u_ffc_checker (.*);
